@@ rtl/dsha_pkg.sv @@
`default_nettype none
package dsha_pkg;

   typedef enum logic [2:0] {
      CSR_MID_AB   = 3'd0,
      CSR_MID_CD   = 3'd1,
      CSR_MID_EF   = 3'd2,
      CSR_MID_GH   = 3'd3,
      CSR_MSG_01   = 3'd4,
      CSR_MSG_2    = 3'd5,
      CSR_POOL     = 3'd6,
      CSR_RESERVED = 3'd7
   } csr_index_type;

   localparam int ROUNDS = 64;
   localparam logic [31:0] PAD_WORD  = 32'h80000000;
   localparam logic [31:0] LEN_FIRST = 32'h00000280;
   localparam logic [31:0] LEN_SECOND = 32'h00000100;

   typedef logic [31:0] word_type;

   // working variables a..h
   typedef struct packed {
      word_type a, b, c, d, e, f, g, h;
   } state_type;

   // sideband carried along the round chain with each nonce
   typedef struct packed {
      logic     valid;
      word_type nonce;
      logic     last;
   } tag_type;

   // values an item carries through its chain: working state, 16-word schedule
   // window, feed-forward base and the tag
   typedef struct packed {
      tag_type             tag;
      state_type           st;
      state_type           base;
      logic [15:0][31:0]   w;
   } cell_data_type;

   localparam word_type K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam state_type IV = '{
      a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
      e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type bswap(input word_type x);
      bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic state_type add_state(input state_type x, input state_type y);
      add_state = '{a: x.a + y.a, b: x.b + y.b, c: x.c + y.c, d: x.d + y.d,
                    e: x.e + y.e, f: x.f + y.f, g: x.g + y.g, h: x.h + y.h};
   endfunction

endpackage
`default_nettype wire

@@ rtl/dsha_round_cell.sv @@
`default_nettype none
// One SHA-256 round plus one schedule step, registered.
module dsha_round_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic [31:0]              round_k,
   input  wire dsha_pkg::cell_data_type  data_in,
   output dsha_pkg::cell_data_type       data_out
);
   import dsha_pkg::*;

   cell_data_type data_ff, data_in_c;
   word_type t1, t2, s0, s1, w_new, ch, maj;
   state_type st;

   always_comb begin
      st  = data_in.st;
      ch  = st.g ^ (st.e & (st.f ^ st.g));
      maj = (st.a & st.b) | (st.c & (st.a | st.b));
      t1  = st.h + (rotr(st.e, 6) ^ rotr(st.e, 11) ^ rotr(st.e, 25)) + ch + round_k
            + data_in.w[0];
      t2  = (rotr(st.a, 2) ^ rotr(st.a, 13) ^ rotr(st.a, 22)) + maj;
      s0  = rotr(data_in.w[1], 7) ^ rotr(data_in.w[1], 18) ^ (data_in.w[1] >> 3);
      s1  = rotr(data_in.w[14], 17) ^ rotr(data_in.w[14], 19) ^ (data_in.w[14] >> 10);
      w_new = data_in.w[0] + s0 + data_in.w[9] + s1;
      data_in_c      = data_in;
      data_in_c.st   = '{a: t1 + t2, b: st.a, c: st.b, d: st.c,
                         e: st.d + t1, f: st.e, g: st.f, h: st.g};
      data_in_c.w    = {w_new, data_in.w[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.tag.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in_c;
      end
   end

   assign data_out = data_ff;
endmodule
`default_nettype wire

@@ rtl/dsha_chain.sv @@
`default_nettype none
// 64 round cells, feed-forward added at the end.
module dsha_chain (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire dsha_pkg::cell_data_type  head,
   output dsha_pkg::tag_type             tail_tag,
   output dsha_pkg::state_type           digest
);
   import dsha_pkg::*;

   cell_data_type link [ROUNDS+1];

   assign link[0] = head;

   for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
      dsha_round_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .round_k (K[i]),
         .data_in (link[i]),
         .data_out(link[i+1])
      );
   end

   assign tail_tag = link[ROUNDS].tag;
   assign digest   = add_state(link[ROUNDS].st, link[ROUNDS].base);
endmodule
`default_nettype wire

@@ rtl/double_sha256_nonce_checker_core.sv @@
`default_nettype none
// Pipeline: 64 round cells per hash, two hashes, one register between, one result
//   register: 130 registers, the first loaded on accepting a req_ transaction and the
//   last (the result register) driving rsp_tvalid.
// Throughput: one nonce per cycle; the whole chain halts together while the
//   result register is full and rsp_tready is low.
// Reset: synchronous, active high; clears valid flags, CSRs and hit count, sets best to all ones.
module double_sha256_nonce_checker_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // nonce
   input  wire logic         req_tlast,   // last_of_range
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] nonce_echo, [32] hit, [33] submit, [65:34] hash_word_six,
   // [66] best_found, [98:67] best_value, [130:99] best_nonce_out,
   // [162:131] hit_total, [167:163] zero
   output logic [167:0]      rsp_tdata,
   output logic              rsp_tlast,   // range_done
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   import dsha_pkg::*;

   // configuration
   state_type mid_ff;
   logic [63:0] msg01_ff;
   word_type msg2_ff;
   logic pool_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= '0; msg01_ff <= '0; msg2_ff <= '0; pool_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MID_AB: {mid_ff.a, mid_ff.b} <= csr_wdata;
            CSR_MID_CD: {mid_ff.c, mid_ff.d} <= csr_wdata;
            CSR_MID_EF: {mid_ff.e, mid_ff.f} <= csr_wdata;
            CSR_MID_GH: {mid_ff.g, mid_ff.h} <= csr_wdata;
            CSR_MSG_01: msg01_ff <= csr_wdata;
            CSR_MSG_2:  msg2_ff  <= csr_wdata[31:0];
            CSR_POOL:   pool_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output register is full and blocked
   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   cell_data_type head1, head2;
   tag_type tag1, tag2;
   state_type dig1, dig2;
   tag_type mid_tag_ff;
   state_type mid_dig_ff;

   always_comb begin
      head1.tag  = '{valid: req_tvalid, nonce: req_tdata, last: req_tlast};
      head1.st   = mid_ff;
      head1.base = mid_ff;
      head1.w    = '0;
      head1.w[0] = msg01_ff[63:32];
      head1.w[1] = msg01_ff[31:0];
      head1.w[2] = msg2_ff;
      head1.w[3] = req_tdata;
      head1.w[4] = PAD_WORD;
      head1.w[15] = LEN_FIRST;
   end

   dsha_chain u_first (
      .clock(clock), .reset(reset), .advance(advance),
      .head(head1), .tail_tag(tag1), .digest(dig1)
   );

   // register between the two hashes keeps the feed-forward add off the next round
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_tag_ff <= tag1;
         mid_dig_ff <= dig1;
      end
   end

   always_comb begin
      head2.tag  = mid_tag_ff;
      head2.st   = IV;
      head2.base = IV;
      head2.w    = '0;
      head2.w[0] = mid_dig_ff.a; head2.w[1] = mid_dig_ff.b;
      head2.w[2] = mid_dig_ff.c; head2.w[3] = mid_dig_ff.d;
      head2.w[4] = mid_dig_ff.e; head2.w[5] = mid_dig_ff.f;
      head2.w[6] = mid_dig_ff.g; head2.w[7] = mid_dig_ff.h;
      head2.w[8] = PAD_WORD;
      head2.w[15] = LEN_SECOND;
   end

   dsha_chain u_second (
      .clock(clock), .reset(reset), .advance(advance),
      .head(head2), .tail_tag(tag2), .digest(dig2)
   );

   // best tracking and hit count, updated as each result is loaded
   word_type best_ff, best_in, lead_nonce_ff, lead_nonce_in, hits_ff, hits_in;
   word_type word6;
   logic hit, take;
   logic [167:0] out_data_ff, out_data_in;
   logic out_last_ff;

   always_comb begin
      word6 = bswap(dig2.g);
      hit   = (dig2.h == '0);
      take  = advance && tag2.valid;
      hits_in = hits_ff + {31'd0, hit};
      best_in = best_ff;
      lead_nonce_in = lead_nonce_ff;
      if (hit && (word6 < best_ff)) begin
         best_in = word6;
         lead_nonce_in = tag2.nonce;
      end
      out_data_in = '0;
      out_data_in[31:0]    = tag2.nonce;
      out_data_in[32]      = hit;
      out_data_in[33]      = hit && pool_ff;
      out_data_in[65:34]   = word6;
      out_data_in[162:131] = hits_in;
      if (tag2.last) begin
         out_data_in[66]      = (best_in != '1);
         out_data_in[98:67]   = best_in;
         out_data_in[130:99]  = lead_nonce_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '1; lead_nonce_ff <= '0; hits_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= tag2.valid;
         end
         if (take) begin
            hits_ff <= hits_in;
            best_ff <= tag2.last ? '1 : best_in;
            lead_nonce_ff <= tag2.last ? '0 : lead_nonce_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= out_data_in;
         out_last_ff <= tag2.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> $stable(out_data_ff))
      else $error("result changed while stalled");
   a_best_reset: assert property (@(posedge clock) disable iff (reset)
      take && tag2.last |=> best_ff == '1 && lead_nonce_ff == '0)
      else $error("best not cleared at range end");
   a_count: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(hits_ff))
      else $error("hit count moved without a result");
endmodule
`default_nettype wire
